// File: hw/rtl/lzw_nibble_compressor_top_macros.svh
// Assertion macros for the LZW nibble compressor RTL.
// Included by lzw_nibble_compressor_top; no dependencies.
`ifndef LZW_NIBBLE_COMPRESSOR_TOP_MACROS_SVH
`define LZW_NIBBLE_COMPRESSOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LNC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define LNC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define LNC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LNC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define LNC_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hw/rtl/lnc_pkg.sv
// Shared types and constants for the LZW nibble compressor.
// No dependencies.
`default_nettype none
package lnc_pkg;
   localparam int SYMBOL_BITS    = 4;
   localparam int NUM_SYMBOLS    = 1 << SYMBOL_BITS;
   localparam int EPOCH_BITS     = 8;
   localparam int CODE_OUT_BITS  = 12;
   localparam int WIDTH_OUT_BITS = 4;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic                      last_of_run;
      logic                      stream_end;
      logic [WIDTH_OUT_BITS-1:0] code_bits;
      logic [CODE_OUT_BITS-1:0]  code;
   } rsp_item_type;
endpackage
`default_nettype wire

// File: hw/rtl/lzw_nibble_compressor_top.sv
// LZW nibble compressor: stream in, code stream out.
// Uses lnc_pkg and lzw_nibble_compressor_top_macros.svh.
//
// req channel: one beat per 4-bit symbol; req_tlast marks the last symbol of a stream.
// rsp channel: one beat per emitted code with its write width; rsp_tuser marks the
// flush code that ends a stream and rsp_tlast the last code caused by one symbol.
// A symbol is looked up in the child table, one synchronous memory of
// 2^(CODE_BITS+4) words, read in the cycle the beat is taken and resolved in the
// next cycle, when the miss entry is written back (with forwarding into a read of
// the same word). A symbol passes the lookup stage register and then the output
// queue before the first code it causes can leave on rsp.
// Throughput: one symbol per cycle; each symbol may yield up to two codes, and the
// rsp side drains one code per cycle through a four-entry output queue. A symbol
// holds in the lookup stage while fewer than two queue entries are free, and req
// stalls behind it.
// Reset starts a clearing sweep that writes zero to every word of the child table,
// during which req_tready stays low. Entries are tagged with a stream epoch; the
// same sweep runs again after every 256th stream.
// When rsp_tready is low, codes hold in the queue and req backs up behind it.
`default_nettype none
`include "lzw_nibble_compressor_top_macros.svh"
module lzw_nibble_compressor_top #(
   parameter int CODE_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] symbol, [7:4] zero
   input  wire logic        req_tlast,   // is_final
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [11:0] code, [15:12] code_bits
   output      logic        rsp_tuser,   // stream_end
   output      logic        rsp_tlast    // last_of_run
);
   localparam int SB        = lnc_pkg::SYMBOL_BITS;
   localparam int EB        = lnc_pkg::EPOCH_BITS;
   localparam int COB       = lnc_pkg::CODE_OUT_BITS;
   localparam int WOB       = lnc_pkg::WIDTH_OUT_BITS;
   localparam int ADDR_BITS = CODE_BITS + SB;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam int WB        = $clog2(CODE_BITS + 1);
   localparam int MEM_W     = EB + CODE_BITS;
   localparam int QPB       = lnc_pkg::QUEUE_PTR_BITS;
   localparam int QCB       = lnc_pkg::QUEUE_CNT_BITS;
   localparam logic [CODE_BITS:0] CODE_LIMIT = {1'b1, {CODE_BITS{1'b0}}};
   localparam logic [CODE_BITS:0] ONE_CODE   = {{CODE_BITS{1'b0}}, 1'b1};
   localparam logic [CODE_BITS:0] NFC_RESET  = (CODE_BITS + 1)'(lnc_pkg::NUM_SYMBOLS);
   localparam logic [WB-1:0]      WIDTH_RESET = WB'(SB + 1);
   localparam logic [WB-1:0]      WIDTH_MAX   = WB'(CODE_BITS);

   logic [MEM_W-1:0]     child_mem_ff [DEPTH];
   logic [MEM_W-1:0]     rd_data_ff;
   logic                 fwd_hit_ff;
   logic [MEM_W-1:0]     fwd_data_ff;

   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 prefix_valid_ff, prefix_valid_in;
   logic [CODE_BITS:0]   nfc_ff, nfc_in;
   logic [WB-1:0]        width_ff, width_in;
   logic [EB-1:0]        epoch_ff, epoch_in;
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   logic                 s1_valid_ff;
   logic [SB-1:0]        s1_sym_ff;
   logic                 s1_final_ff;
   logic [ADDR_BITS-1:0] s1_idx_ff;

   lnc_pkg::rsp_item_type q_ff [lnc_pkg::QUEUE_DEPTH];
   logic [QPB-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QCB-1:0]       count_ff;

   logic [MEM_W-1:0]     child_word;
   logic [CODE_BITS-1:0] child_code;
   logic [EB-1:0]        child_tag;
   logic [CODE_BITS-1:0] sym_code;
   logic [CODE_BITS:0]   nfc_inc;
   logic                 hit, room, s1_fire, req_fire, rsp_fire;
   logic                 miss, add_entry, start_clear;
   logic [CODE_BITS-1:0] prefix_mid;
   logic [WB-1:0]        width_mid;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_wa, mem_ra;
   logic [MEM_W-1:0]     mem_wd;
   lnc_pkg::rsp_item_type miss_item, flush_item, push0, push1;
   logic [1:0]           npush;

   assign child_word = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign child_code = child_word[CODE_BITS-1:0];
   assign child_tag  = child_word[MEM_W-1 -: EB];
   assign hit        = (child_tag == epoch_ff) && (child_code != '0);
   assign sym_code   = {{(CODE_BITS-SB){1'b0}}, s1_sym_ff};
   assign nfc_inc    = nfc_ff + ONE_CODE;

   assign room       = count_ff <= QCB'(lnc_pkg::QUEUE_DEPTH - 2);
   assign s1_fire    = s1_valid_ff && room;
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_fire);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      prefix_mid      = prefix_ff;
      width_mid       = width_ff;
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      nfc_in          = nfc_ff;
      width_in        = width_ff;
      epoch_in        = epoch_ff;
      miss            = 1'b0;
      add_entry       = 1'b0;
      start_clear     = 1'b0;
      if (s1_fire) begin
         if (!prefix_valid_ff) begin
            prefix_mid      = sym_code;
            prefix_valid_in = 1'b1;
         end else if (hit) begin
            prefix_mid = child_code;
         end else begin
            miss       = 1'b1;
            prefix_mid = sym_code;
            if (nfc_ff < CODE_LIMIT) begin
               add_entry = 1'b1;
               nfc_in    = nfc_inc;
               if (width_ff < WIDTH_MAX && nfc_inc == (ONE_CODE << width_ff)) begin
                  width_mid = width_ff + WB'(1);
               end
            end
         end
         prefix_in = prefix_mid;
         width_in  = width_mid;
         if (s1_final_ff) begin
            prefix_in       = '0;
            prefix_valid_in = 1'b0;
            nfc_in          = NFC_RESET;
            width_in        = WIDTH_RESET;
            epoch_in        = epoch_ff + EB'(1);
            start_clear     = epoch_ff == '1;
         end
      end
   end

   always_comb begin
      miss_item.code        = COB'({{COB{1'b0}}, prefix_ff});
      miss_item.code_bits   = WOB'({{WOB{1'b0}}, width_ff});
      miss_item.stream_end  = 1'b0;
      miss_item.last_of_run = !s1_final_ff;
      flush_item.code        = COB'({{COB{1'b0}}, prefix_mid});
      flush_item.code_bits   = WOB'({{WOB{1'b0}}, width_mid});
      flush_item.stream_end  = 1'b1;
      flush_item.last_of_run = 1'b1;
      push0 = miss ? miss_item : flush_item;
      push1 = flush_item;
      npush = 2'(miss) + 2'(s1_fire && s1_final_ff);
   end

   assign mem_ra = {prefix_in, req_tdata[SB-1:0]};
   assign mem_we = clr_busy_ff || (s1_fire && add_entry);
   assign mem_wa = clr_busy_ff ? clr_addr_ff : s1_idx_ff;
   assign mem_wd = clr_busy_ff ? '0 : {epoch_ff, nfc_ff[CODE_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         child_mem_ff[mem_wa] <= mem_wd;
      end
      if (req_fire) begin
         rd_data_ff  <= child_mem_ff[mem_ra];
         fwd_hit_ff  <= mem_we && (mem_wa == mem_ra);
         fwd_data_ff <= mem_wd;
         s1_sym_ff   <= req_tdata[SB-1:0];
         s1_final_ff <= req_tlast;
         s1_idx_ff   <= mem_ra;
      end
      if (npush != 2'd0) begin
         q_ff[wr_ptr_ff] <= push0;
      end
      if (npush == 2'd2) begin
         q_ff[wr_ptr_ff + QPB'(1)] <= push1;
      end
   end

   assign clr_busy_in = start_clear || (clr_busy_ff && (clr_addr_ff != '1));

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         nfc_ff          <= NFC_RESET;
         width_ff        <= WIDTH_RESET;
         epoch_ff        <= '0;
         clr_busy_ff     <= 1'b1;
         clr_addr_ff     <= '0;
         s1_valid_ff     <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         prefix_ff       <= prefix_in;
         prefix_valid_ff <= prefix_valid_in;
         nfc_ff          <= nfc_in;
         width_ff        <= width_in;
         epoch_ff        <= epoch_in;
         clr_busy_ff     <= clr_busy_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         wr_ptr_ff <= wr_ptr_ff + QPB'(npush);
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + QPB'(1);
         end
         count_ff <= count_ff + QCB'(npush) - QCB'(rsp_fire);
      end
   end

   always_comb begin
      rsp_tdata = {q_ff[rd_ptr_ff].code_bits, q_ff[rd_ptr_ff].code};
      rsp_tuser = q_ff[rd_ptr_ff].stream_end;
      rsp_tlast = q_ff[rd_ptr_ff].last_of_run;
   end

   `LNC_ASSERT_NEVER(a_queue_overflow, clock, reset, count_ff > QCB'(lnc_pkg::QUEUE_DEPTH))
   `LNC_ASSERT_IMPLY(a_no_add_in_clear, clock, reset, s1_fire && add_entry, !clr_busy_ff)
   `LNC_ASSERT_NEXT(a_code_advance, clock, reset, add_entry && !s1_final_ff, nfc_ff == $past(nfc_inc))
   `LNC_ASSERT_IMPLY(a_no_miss_at_root, clock, reset, s1_fire && !prefix_valid_ff, npush != 2'd2)
endmodule
`default_nettype wire

// File: tb/tb_lzw_nibble_compressor_top.sv
// Self-checking testbench for lzw_nibble_compressor_top: symbol streams in, codes checked
// against an in-bench LZW predictor with its own copy of the child table.
// Depends on lnc_pkg and the compressor RTL only.
module tb_lzw_nibble_compressor_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CODE_BITS    = 12;
   localparam int CODE_LIMIT   = 1 << CODE_BITS;
   localparam int FILL_CODE    = 256;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [3:0] symbol, [7:4] zero
   logic        req_tlast  = 1'b0;    // is_final
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [11:0] code, [15:12] code_bits
   logic        rsp_tuser;            // stream_end
   logic        rsp_tlast;            // last_of_run

   lzw_nibble_compressor_top #(
      .CODE_BITS(CODE_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   // predictor state
   bit   [11:0] dict_child [65536];
   int          dict_used [$];
   logic [11:0] pfx_code  = '0;
   logic        pfx_valid = 1'b0;
   logic [12:0] next_code = 13'd16;
   logic [3:0]  cur_width = 4'd5;

   lnc_pkg::rsp_item_type expected_codes [$];

   int req_idle_pct = 23;
   int rsp_idle_pct = 23;
   int items_sent   = 0;
   int beats_seen   = 0;
   int mismatches   = 0;
   int cycles       = 0;

   task automatic queue_expected(input lnc_pkg::rsp_item_type item);
      expected_codes = {expected_codes, item};
   endtask

   task automatic predict_codes(input logic [3:0] sym, input logic fin);
      logic [15:0]  slot;
      logic [11:0]  child;
      lnc_pkg::rsp_item_type item;
      if (!pfx_valid) begin
         pfx_code  = {8'h00, sym};
         pfx_valid = 1'b1;
      end else begin
         slot  = {pfx_code, sym};
         child = dict_child[slot];
         if (child != 0) begin
            pfx_code = child;
         end else begin
            item.code        = pfx_code;
            item.code_bits   = cur_width;
            item.stream_end  = 1'b0;
            item.last_of_run = !fin;
            queue_expected(item);
            if (next_code < CODE_LIMIT) begin
               dict_child[slot] = next_code[11:0];
               dict_used = {dict_used, int'(slot)};
               next_code++;
               if (cur_width < CODE_BITS && int'(next_code) == (1 << cur_width))
                  cur_width++;
            end
            pfx_code = {8'h00, sym};
         end
      end
      if (fin) begin
         item.code        = pfx_code;
         item.code_bits   = cur_width;
         item.stream_end  = 1'b1;
         item.last_of_run = 1'b1;
         queue_expected(item);
         foreach (dict_used[i]) dict_child[dict_used[i]] = '0;
         dict_used.delete();
         pfx_code  = '0;
         pfx_valid = 1'b0;
         next_code = 13'd16;
         cur_width = 4'd5;
      end
   endtask

   task automatic push_symbol(input logic [3:0] sym, input logic fin);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, sym};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_codes(sym, fin);
      items_sent++;
   endtask

   task automatic send_stream(input int len, input int top_sym);
      for (int i = 0; i < len; i++)
         push_symbol(4'($urandom_range(0, top_sym)), i == len - 1);
   endtask

   // hold off new beats until every predicted code has been seen
   task automatic hold_requests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_codes.size() != 0) @(posedge clock);
   endtask

   // prefer a symbol that misses, else one leading to a prefix that can still grow
   function automatic logic [3:0] pick_fill_symbol();
      logic [3:0]  missing [$];
      logic [3:0]  fertile [$];
      logic [11:0] child;
      if (!pfx_valid) return 4'($urandom_range(0, 15));
      for (int s = 0; s < 16; s++) begin
         child = dict_child[{pfx_code, 4'(s)}];
         if (child == 0) begin
            missing = {missing, 4'(s)};
         end else begin
            for (int t = 0; t < 16; t++) begin
               if (dict_child[{child, 4'(t)}] == 0) begin
                  fertile = {fertile, 4'(s)};
                  break;
               end
            end
         end
      end
      if (missing.size() != 0) return missing[$urandom_range(0, missing.size() - 1)];
      if (fertile.size() != 0) return fertile[$urandom_range(0, fertile.size() - 1)];
      return 4'($urandom_range(0, 15));
   endfunction

   task automatic test_directed_streams();
      // lone final symbols at both ends of the range
      push_symbol(4'd0, 1'b1);
      push_symbol(4'd15, 1'b1);
      // miss, hit, then final on a miss
      push_symbol(4'd3, 1'b0);
      push_symbol(4'd3, 1'b0);
      push_symbol(4'd3, 1'b0);
      push_symbol(4'd3, 1'b1);
      // final on a hit
      push_symbol(4'd1, 1'b0);
      push_symbol(4'd2, 1'b0);
      push_symbol(4'd1, 1'b0);
      push_symbol(4'd2, 1'b1);
      // growing chain of one symbol
      repeat (6) push_symbol(4'd15, 1'b0);
      push_symbol(4'd0, 1'b1);
   endtask

   task automatic test_random_streams();
      int goal;
      goal = items_sent + 120;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) < 7)
            send_stream($urandom_range(1, 12), $urandom_range(1, 15));
         else
            send_stream($urandom_range(13, 80), $urandom_range(1, 15));
      end
   endtask

   task automatic test_unthrottled_streams();
      int goal;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      goal = items_sent + 60;
      while (items_sent < goal)
         send_stream($urandom_range(1, 30), $urandom_range(1, 15));
      req_idle_pct = 23;
      rsp_idle_pct = 23;
   endtask

   // enough one-symbol streams to wrap the stream tag
   task automatic test_epoch_rollover();
      repeat (256) send_stream(1, 3);
   endtask

   // grow the code width up to nine bits within one stream
   task automatic test_width_growth();
      while (int'(next_code) < FILL_CODE) push_symbol(pick_fill_symbol(), 1'b0);
      repeat (10) push_symbol(4'($urandom_range(0, 15)), 1'b0);
      push_symbol(4'($urandom_range(0, 15)), 1'b1);
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at rsp beat %0d: %s expected %0d got %0d", beats_seen, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_check
      lnc_pkg::rsp_item_type seen;
      lnc_pkg::rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.code        = rsp_tdata[11:0];
            seen.code_bits   = rsp_tdata[15:12];
            seen.stream_end  = rsp_tuser;
            seen.last_of_run = rsp_tlast;
            if (expected_codes.size() == 0) begin
               report_mismatch("code with none pending", 0, seen.code);
            end else begin
               want = expected_codes.pop_front();
               if (seen.code != want.code)
                  report_mismatch("code", want.code, seen.code);
               if (seen.code_bits != want.code_bits)
                  report_mismatch("code_bits", want.code_bits, seen.code_bits);
               if (seen.stream_end != want.stream_end)
                  report_mismatch("stream_end", want.stream_end, seen.stream_end);
               if (seen.last_of_run != want.last_of_run)
                  report_mismatch("last_of_run", want.last_of_run, seen.last_of_run);
            end
            beats_seen++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_streams();
      hold_requests();
      test_random_streams();
      test_unthrottled_streams();
      hold_requests();
      test_epoch_rollover();
      test_width_growth();
      hold_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_codes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lnc_pkg.sv
hw/rtl/lzw_nibble_compressor_top.sv
tb/tb_lzw_nibble_compressor_top.sv
